/* rtl/core/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg
// Types and constants shared by the stable priority queue core and its cells.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int DATA_BITS   = 32;
   localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);

   localparam logic ACTION_INSERT = 1'b0;
   localparam logic ACTION_POP    = 1'b1;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic        action;
      logic [31:0] item_value;
      logic [31:0] item_priority;
   } spq_req_type;

   typedef struct packed {
      logic [31:0] front_value;
      logic [1:0]  status;
      logic [4:0]  entry_count;
   } spq_rsp_type;

   // broadcast to every cell
   typedef struct packed {
      logic                 insert;
      logic                 pop;
      logic [DATA_BITS-1:0] value;
      logic [31:0]          prio;
   } spq_cmd_type;

   // what a cell shows its neighbors
   typedef struct packed {
      logic                 valid;
      logic                 keep;
      logic [DATA_BITS-1:0] value;
      logic [31:0]          prio;
   } spq_link_type;

endpackage

/* rtl/core/spq_cell.sv */
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted queue: holds, shifts right on insert, left on pop.
// ----------------------------------------------------------------------------
module spq_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  spq_pkg::spq_cmd_type  cmd,
   input  spq_pkg::spq_link_type left,
   input  spq_pkg::spq_link_type right,
   output spq_pkg::spq_link_type slot
);
   import spq_pkg::*;

   logic                 valid_ff;
   logic                 valid_in;
   logic [DATA_BITS-1:0] value_ff;
   logic [DATA_BITS-1:0] value_in;
   logic [31:0]          priority_ff;
   logic [31:0]          priority_in;
   logic                 keep;

   assign keep = valid_ff && (priority_ff >= cmd.prio);

   always_comb begin
      valid_in    = valid_ff;
      value_in    = value_ff;
      priority_in = priority_ff;
      if (cmd.insert && !keep) begin
         if (left.keep) begin
            valid_in    = 1'b1;
            value_in    = cmd.value;
            priority_in = cmd.prio;
         end else begin
            valid_in    = left.valid;
            value_in    = left.value;
            priority_in = left.prio;
         end
      end else if (cmd.pop) begin
         valid_in    = right.valid;
         value_in    = right.value;
         priority_in = right.prio;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff    <= value_in;
      priority_ff <= priority_in;
   end

   assign slot.valid = valid_ff;
   assign slot.keep  = keep;
   assign slot.value = value_ff;
   assign slot.prio  = priority_ff;

   // entries stay packed toward the head and sorted
   a_packed: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> left.valid)
      else $error("spq_cell: gap in front of a held entry");

   a_sorted: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (left.prio >= priority_ff))
      else $error("spq_cell: priority order broken");

   a_pop_tail: assert property (@(posedge clock) disable iff (reset)
      (cmd.pop && !right.valid) |=> !valid_ff)
      else $error("spq_cell: slot still held after pop from the tail");

endmodule

/* rtl/core/stable_priority_queue_core.sv */
// ----------------------------------------------------------------------------
// stable_priority_queue_core
// Bounded priority queue, descending priority, arrival order among equals.
// ----------------------------------------------------------------------------
// Request channel: a transfer happens on a rising edge with start high and
// busy low; req_data carries the action (insert or pop), data and priority.
// busy is always low, so one request may be issued every cycle.
// Result channel: exactly one result per request, shown on rsp_data for one
// cycle with rsp_strobe high, in the cycle after the request transfer. The
// receiver cannot stall it.
// Throughput 1 request per cycle: every slot sits in its
// own cell of a chain, all cells compare against the new priority at once
// and shift toward their neighbor in the same cycle.
// Insert on a full queue reports full and is dropped; pop on an empty queue
// reports empty and returns zero.
// Reset (synchronous) empties the queue and removes any pending result;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
module stable_priority_queue_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  spq_pkg::spq_req_type req_data,
   output logic                rsp_strobe,
   output spq_pkg::spq_rsp_type rsp_data
);
   import spq_pkg::*;

   spq_link_type             links [QUEUE_DEPTH];
   spq_link_type             head_link;
   spq_link_type             tail_link;
   spq_cmd_type              cmd;
   logic                     accept;
   logic                     full;
   logic                     empty;
   logic [COUNT_BITS-1:0]    count_ff;
   logic [COUNT_BITS-1:0]    count_in;
   logic                     rsp_strobe_ff;
   spq_rsp_type              rsp_ff;
   spq_rsp_type              rsp_in;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign full   = links[QUEUE_DEPTH-1].valid;
   assign empty  = !links[0].valid;

   assign head_link.valid = 1'b1;
   assign head_link.keep  = 1'b1;
   assign head_link.value = '0;
   assign head_link.prio  = '1;

   assign tail_link.valid = 1'b0;
   assign tail_link.keep  = 1'b0;
   assign tail_link.value = '0;
   assign tail_link.prio  = '0;

   assign cmd.insert = accept && (req_data.action == ACTION_INSERT) && !full;
   assign cmd.pop    = accept && (req_data.action == ACTION_POP) && !empty;
   assign cmd.value  = DATA_BITS'(req_data.item_value);
   assign cmd.prio   = req_data.item_priority;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      spq_link_type left_link;
      spq_link_type right_link;
      if (i == 0) begin : g_first
         assign left_link = head_link;
      end else begin : g_inner_l
         assign left_link = links[i-1];
      end
      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign right_link = tail_link;
      end else begin : g_inner_r
         assign right_link = links[i+1];
      end
      spq_cell u_cell (
         .clock (clock),
         .reset (reset),
         .cmd   (cmd),
         .left  (left_link),
         .right (right_link),
         .slot  (links[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.insert) begin
         count_in = count_ff + COUNT_BITS'(1);
      end else if (cmd.pop) begin
         count_in = count_ff - COUNT_BITS'(1);
      end
      rsp_in.front_value = '0;
      rsp_in.status      = STATUS_DONE;
      rsp_in.entry_count = 5'(count_in);
      if (req_data.action == ACTION_INSERT) begin
         if (full) begin
            rsp_in.status = STATUS_FULL;
         end
      end else begin
         if (empty) begin
            rsp_in.status = STATUS_EMPTY;
         end else begin
            rsp_in.front_value = 32'(links[0].value);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_strobe_ff <= accept;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   logic [QUEUE_DEPTH-1:0] valid_vec;
   for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_vec
      assign valid_vec[k] = links[k].valid;
   end

   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff == COUNT_BITS'($countones(valid_vec)))
      else $error("spq: count does not match held entries");

   a_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe && (rsp_data.entry_count == 5'(count_ff)))
      else $error("spq: result missing or count wrong");

   a_empty: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.action == ACTION_POP && empty) |=>
      (rsp_data.status == STATUS_EMPTY) && (rsp_data.front_value == '0)
      && $stable(count_ff))
      else $error("spq: pop on empty misreported");

   a_full: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.action == ACTION_INSERT && full) |=>
      (rsp_data.status == STATUS_FULL) && $stable(count_ff))
      else $error("spq: insert on full misreported");

endmodule
